FILE: src/bpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types, constants and Q16.16 arithmetic helpers for the bivariate
// polynomial evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int CIDX_W   = 7;
  localparam int CFG_W    = 4;

  localparam int DEF_MAX_DEGREE  = 12;
  localparam int DEF_TABLE_DEPTH = 91;

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SET_Y = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CO_ROW,
    ST_CO_MUL,
    ST_CO_ACC,
    ST_EV_ROW0,
    ST_EV_XP,
    ST_EV_RM,
    ST_EV_FIN
  } state_t;

  // full product, arithmetic shift right by 16, saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] p;
    logic signed [2*DATA_W-1:0] q;
    p = 64'(a) * 64'(b);
    q = p >>> 16;
    if (q[2*DATA_W-1:DATA_W-1] != {(DATA_W+1){q[DATA_W-1]}}) begin
      qmul = q[2*DATA_W-1] ? Q_MIN : Q_MAX;
    end else begin
      qmul = q[DATA_W-1:0];
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] qadd(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = 33'(a) + 33'(b);
    if (s[DATA_W] != s[DATA_W-1]) begin
      qadd = s[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      qadd = s[DATA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/bpe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: src/bivariate_polynomial_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bivariate_polynomial_evaluator
// Evaluates p(x,y) in signed Q16.16 from a coefficient table held in RAM.
// ----------------------------------------------------------------------------
// Usage: a coefficient write is done as it is accepted and leaves the block
// idle. Set-y and evaluate items are paced by the single shared saturating
// multiplier, which serves the power chain and the coefficient products in
// alternate cycles, and by the registered read data of the coefficient and
// row RAMs. Tables come out of reset cleared through per-entry valid bits,
// so there is no clearing pass. Items are taken one at a time; a finished
// result sits in the output register while the next item is accepted.
module bivariate_polynomial_evaluator #(
  parameter int MAX_DEGREE  = bpe_pkg::DEF_MAX_DEGREE,
  parameter int TABLE_DEPTH = bpe_pkg::DEF_TABLE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bpe_pkg::OP_W-1:0]          in_operation,
  input  wire logic [bpe_pkg::CIDX_W-1:0]        in_coef_index,
  input  wire logic signed [bpe_pkg::DATA_W-1:0] in_coef_value,
  input  wire logic signed [bpe_pkg::DATA_W-1:0] in_coordinate,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bpe_pkg::DATA_W-1:0]      out_poly_value,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bpe_pkg::CFG_W-1:0]         cfg_wr_data
);

  import bpe_pkg::*;

  localparam int ROWS    = MAX_DEGREE + 1;
  localparam int DEG_W   = $clog2(ROWS);
  localparam int TA_W    = $clog2(TABLE_DEPTH);
  localparam int IDX_LIM = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
  localparam int IDX_W   = $clog2(IDX_LIM + TABLE_DEPTH + MAX_DEGREE + 3);

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         deg_cfg_r;
  logic [DEG_W-1:0]         deg_r, deg_nxt;
  logic [DEG_W-1:0]         i_r, i_nxt;
  logic [DEG_W-1:0]         j_r, j_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         start_r, start_nxt;
  logic signed [DATA_W-1:0] coord_r, coord_nxt;
  logic signed [DATA_W-1:0] pw_r, pw_nxt;
  logic signed [DATA_W-1:0] acc_r, acc_nxt;
  logic signed [DATA_W-1:0] prod_r, prod_nxt;
  logic                     thit_r, thit_nxt;
  logic                     rhit_r, rhit_nxt;
  logic [TABLE_DEPTH-1:0]   tvalid_r, tvalid_nxt;
  logic [ROWS-1:0]          rvalid_r, rvalid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;

  logic                     accept;
  op_t                      op;
  logic [DEG_W-1:0]         deg_act;
  logic [IDX_W-1:0]         t_rd_idx;
  logic [IDX_W-1:0]         idx_step;
  logic signed [DATA_W-1:0] mul_a, mul_b, mul_q;
  logic signed [DATA_W-1:0] sum;
  logic signed [DATA_W-1:0] coef;
  logic signed [DATA_W-1:0] rowc;

  logic                     t_we;
  logic [TA_W-1:0]          t_waddr;
  logic [DATA_W-1:0]        t_rdata;
  logic                     r_we;
  logic [DEG_W-1:0]         r_waddr, r_raddr;
  logic [DATA_W-1:0]        r_wdata, r_rdata;

  assign in_stall       = !rst_n || (state_r != ST_IDLE);
  assign accept         = in_valid && !in_stall;
  assign op             = op_t'(in_operation);
  assign out_valid      = out_valid_r;
  assign out_poly_value = out_value_r;

  assign deg_act = (int'(deg_cfg_r) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(deg_cfg_r);

  // coefficient writes go straight from the input port
  assign t_we    = accept && (op == OP_WRITE) && (int'(in_coef_index) < TABLE_DEPTH);
  assign t_waddr = TA_W'(in_coef_index);

  assign mul_q    = qmul(mul_a, mul_b);
  assign sum      = qadd(acc_r, prod_r);
  assign coef     = thit_r ? signed'(t_rdata) : '0;
  assign rowc     = rhit_r ? signed'(r_rdata) : '0;
  assign idx_step = idx_r + IDX_W'(i_r) + IDX_W'(j_r) + IDX_W'(2);

  bpe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TABLE_DEPTH)
  ) u_coef_ram (
    .clk    (clk),
    .wr_en  (t_we),
    .wr_addr(t_waddr),
    .wr_data(in_coef_value),
    .rd_addr(TA_W'(t_rd_idx)),
    .rd_data(t_rdata)
  );

  bpe_ram #(
    .WIDTH(DATA_W),
    .DEPTH(ROWS)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (r_we),
    .wr_addr(r_waddr),
    .wr_data(r_wdata),
    .rd_addr(r_raddr),
    .rd_data(r_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      deg_cfg_r   <= '0;
      tvalid_r    <= '0;
      rvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        deg_cfg_r <= cfg_wr_data;
      end
      tvalid_r    <= tvalid_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    deg_r       <= deg_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    idx_r       <= idx_nxt;
    start_r     <= start_nxt;
    coord_r     <= coord_nxt;
    pw_r        <= pw_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    thit_r      <= thit_nxt;
    rhit_r      <= rhit_nxt;
    out_value_r <= out_value_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    deg_nxt       = deg_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    coord_nxt     = coord_r;
    pw_nxt        = pw_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    thit_nxt      = thit_r;
    rhit_nxt      = rhit_r;
    tvalid_nxt    = tvalid_r;
    rvalid_nxt    = rvalid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    t_rd_idx      = idx_r;
    r_raddr       = i_r;
    r_we          = 1'b0;
    r_waddr       = i_r;
    r_wdata       = sum;
    mul_a         = pw_r;
    mul_b         = coord_r;

    if (t_we) begin
      tvalid_nxt[t_waddr] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_SET_Y: begin
              deg_nxt    = deg_act;
              coord_nxt  = in_coordinate;
              i_nxt      = '0;
              start_nxt  = '0;
              rvalid_nxt = '0;
              state_nxt  = ST_CO_ROW;
            end
            OP_EVAL: begin
              deg_nxt   = deg_act;
              coord_nxt = in_coordinate;
              r_raddr   = '0;
              rhit_nxt  = rvalid_r[0];
              state_nxt = ST_EV_ROW0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CO_ROW: begin
        t_rd_idx  = start_r;
        thit_nxt  = (int'(start_r) < TABLE_DEPTH) && tvalid_r[TA_W'(start_r)];
        idx_nxt   = start_r;
        j_nxt     = '0;
        pw_nxt    = Q_ONE;
        acc_nxt   = '0;
        state_nxt = ST_CO_MUL;
      end

      ST_CO_MUL: begin
        mul_a     = coef;
        mul_b     = pw_r;
        prod_nxt  = mul_q;
        state_nxt = ST_CO_ACC;
      end

      ST_CO_ACC: begin
        // advance the y power while folding in the last product
        pw_nxt  = mul_q;
        acc_nxt = sum;
        if ((DEG_W+1)'(j_r) + (DEG_W+1)'(i_r) < (DEG_W+1)'(deg_r)) begin
          t_rd_idx  = idx_step;
          thit_nxt  = (int'(idx_step) < TABLE_DEPTH) && tvalid_r[TA_W'(idx_step)];
          idx_nxt   = idx_step;
          j_nxt     = j_r + DEG_W'(1);
          state_nxt = ST_CO_MUL;
        end else begin
          r_we                = 1'b1;
          rvalid_nxt[i_r]     = 1'b1;
          if (i_r < deg_r) begin
            start_nxt = start_r + IDX_W'(i_r) + IDX_W'(1);
            i_nxt     = i_r + DEG_W'(1);
            state_nxt = ST_CO_ROW;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_EV_ROW0: begin
        acc_nxt  = rowc;
        prod_nxt = '0;
        pw_nxt   = Q_ONE;
        i_nxt    = DEG_W'(1);
        if (deg_r == '0) begin
          state_nxt = ST_EV_FIN;
        end else begin
          state_nxt = ST_EV_XP;
        end
      end

      ST_EV_XP: begin
        pw_nxt    = mul_q;
        acc_nxt   = sum;
        r_raddr   = i_r;
        rhit_nxt  = rvalid_r[i_r];
        state_nxt = ST_EV_RM;
      end

      ST_EV_RM: begin
        mul_a    = rowc;
        mul_b    = pw_r;
        prod_nxt = mul_q;
        if (i_r == deg_r) begin
          state_nxt = ST_EV_FIN;
        end else begin
          i_nxt     = i_r + DEG_W'(1);
          state_nxt = ST_EV_XP;
        end
      end

      ST_EV_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = sum;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/bpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpe_checker
// Port-level checks for the bivariate polynomial evaluator.
// ----------------------------------------------------------------------------
module bpe_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic [bpe_pkg::OP_W-1:0]          in_operation,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [bpe_pkg::DATA_W-1:0] out_poly_value
);

  import bpe_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_poly_value))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a coefficient write does not make the block busy
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == OP_WRITE) |=> !in_stall)
    else $error("coefficient write did not complete in one cycle");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ((in_operation == OP_SET_Y) || (in_operation == OP_EVAL)) |=> in_stall)
    else $error("block not busy after set-y or evaluate item");

  // a new result only appears at the end of an evaluation
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind bivariate_polynomial_evaluator bpe_checker u_bpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_operation  (in_operation),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_poly_value(out_poly_value)
);
`default_nettype wire

FILE: bench/bivariate_polynomial_evaluator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bivariate_polynomial_evaluator_test
// Self-checking bench for the Q16.16 bivariate polynomial evaluator. Items
// are queued by a sequencer, sent in random bursts and checked against a
// bit-true predictor of the coefficient table, row collapse and x evaluation.
// ----------------------------------------------------------------------------
module bivariate_polynomial_evaluator_test;
  import bpe_pkg::*;

  localparam int TBL_DEPTH     = DEF_TABLE_DEPTH;
  localparam int MAX_DEG       = DEF_MAX_DEGREE;
  // a set-y item gives no result
  localparam int SETTLE_CYCLES = 260;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 62;
  localparam int TIMEOUT_NS    = 10_000_000;

  typedef struct {
    op_t                      op;
    logic [CIDX_W-1:0]        idx;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] coord;
  } poly_cmd_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           in_operation   = '0;
  logic [CIDX_W-1:0]         in_coef_index  = '0;
  logic signed [DATA_W-1:0]  in_coef_value  = '0;
  logic signed [DATA_W-1:0]  in_coordinate  = '0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  logic signed [DATA_W-1:0]  out_poly_value;
  logic                      cfg_wr_en      = 1'b0;
  logic [CFG_W-1:0]          cfg_wr_data    = '0;

  // predictor state
  logic signed [DATA_W-1:0]  coef_tbl [TBL_DEPTH];
  logic signed [DATA_W-1:0]  row_coef [MAX_DEG+1];
  logic [CFG_W-1:0]          degree_reg = '0;

  poly_cmd_t                 pending_cmds [$];
  logic signed [DATA_W-1:0]  expected_values [$];

  int n_queued = 0, n_accepted = 0, results_seen = 0, fail_count = 0;
  int n_writes = 0, n_collapses = 0, n_evals = 0, n_ignored = 0, n_degrees = 0;
  int burst_left = 8, gap_left = 0;
  int hold_left = 0, next_hold_at = 25, mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic signed [DATA_W-1:0] want_value;

  bivariate_polynomial_evaluator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_coef_index  (in_coef_index),
    .in_coef_value  (in_coef_value),
    .in_coordinate  (in_coordinate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_poly_value (out_poly_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [DATA_W-1:0] fx_clip(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // shift of the full product rounds toward minus infinity
  function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    longint prod;
    prod = (longint'(a) * longint'(b)) >>> 16;
    return fx_clip(prod);
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    return fx_clip(longint'(a) + longint'(b));
  endfunction

  function automatic int active_deg();
    return (degree_reg > MAX_DEG) ? MAX_DEG : int'(degree_reg);
  endfunction

  function automatic void collapse_rows(input logic signed [DATA_W-1:0] y);
    int d, start, idx, i, j;
    logic signed [DATA_W-1:0] yp, acc;
    d = active_deg();
    start = 0;
    for (i = 0; i <= MAX_DEG; i++) row_coef[i] = '0;
    for (i = 0; i <= d; i++) begin
      idx = start;
      yp = Q_ONE;
      acc = '0;
      // walk c(i,0), c(i,1) and on, whose indexes grow by i+j+2 per step
      for (j = 0; j <= d - i; j++) begin
        acc = fx_add(acc, fx_mul((idx < TBL_DEPTH) ? coef_tbl[idx] : '0, yp));
        idx += i + j + 2;
        yp = fx_mul(yp, y);
      end
      row_coef[i] = acc;
      start += i + 1;
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] eval_rows(input logic signed [DATA_W-1:0] x);
    int k;
    logic signed [DATA_W-1:0] acc, xp;
    acc = row_coef[0];
    xp = Q_ONE;
    for (k = 1; k <= active_deg(); k++) begin
      xp = fx_mul(xp, x);
      acc = fx_add(acc, fx_mul(row_coef[k], xp));
    end
    return acc;
  endfunction

  function automatic void apply_cmd(input op_t op, input logic [CIDX_W-1:0] idx,
                                    input logic signed [DATA_W-1:0] value,
                                    input logic signed [DATA_W-1:0] coord);
    case (op)
      OP_WRITE: begin
        if (idx < TBL_DEPTH) begin
          coef_tbl[idx] = value;
          n_writes++;
        end else begin
          n_ignored++;
        end
      end
      OP_SET_Y: begin
        collapse_rows(coord);
        n_collapses++;
      end
      OP_EVAL: begin
        expected_values.push_back(eval_rows(coord));
        n_evals++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return Q_ONE;
      default: return 32'shFFFF_0000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return pick_extreme();
      1, 2:    return $urandom;
      default: return int'($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  // mostly within +-1.5 so high powers stay clear of saturation
  function automatic logic signed [DATA_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return pick_extreme();
      1:       return $urandom;
      2:       return int'($urandom_range(0, 255)) - 128;
      default: return int'($urandom_range(0, 196608)) - 98304;
    endcase
  endfunction

  task automatic push_cmd(input op_t op, input logic [CIDX_W-1:0] idx,
                          input logic signed [DATA_W-1:0] value,
                          input logic signed [DATA_W-1:0] coord);
    pending_cmds.push_back('{op, idx, value, coord});
    n_queued++;
  endtask

  task automatic build_phase(input int want);
    int made, span, k, n, n_eval;
    op_t op;
    logic [CIDX_W-1:0] idx;
    made = 0;
    span = (active_deg() + 1) * (active_deg() + 2) / 2;
    while (made < want) begin
      if ($urandom_range(0, 9) < 8) begin
        // coefficient updates, a new y, then a few x points
        n = $urandom_range(0, (span < 6) ? span : 6);
        for (k = 0; k < n; k++) begin
          push_cmd(OP_WRITE, CIDX_W'($urandom_range(0, span - 1)), pick_coef(), $urandom);
        end
        if ($urandom_range(0, 9) != 0) begin
          push_cmd(OP_SET_Y, CIDX_W'($urandom_range(0, 127)), $urandom, pick_coord());
          made++;
        end
        n_eval = $urandom_range(1, 4);
        for (k = 0; k < n_eval; k++) begin
          push_cmd(OP_EVAL, CIDX_W'($urandom_range(0, 127)), $urandom, pick_coord());
        end
        made += n + n_eval;
      end else begin
        op  = op_t'($urandom_range(0, 3));
        idx = CIDX_W'($urandom_range(0, 127));
        push_cmd(op, idx, $urandom, $urandom);
        if (op != OP_NONE && !(op == OP_WRITE && idx >= TBL_DEPTH)) made++;
      end
    end
  endtask

  task automatic set_degree(input logic [CFG_W-1:0] d);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    degree_reg = d;
    n_degrees++;
    @(negedge clk);
  endtask

  // wait until every queued item is taken and every result is back
  task automatic drain(input int settle);
    do @(negedge clk); while (n_accepted != n_queued || expected_values.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------- sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_cmd(op_t'(in_operation), in_coef_index, in_coef_value, in_coordinate);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_valid      <= 1'b1;
          in_operation  <= pending_cmds[0].op;
          in_coef_index <= pending_cmds[0].idx;
          in_coef_value <= pending_cmds[0].value;
          in_coordinate <= pending_cmds[0].coord;
          void'(pending_cmds.pop_front());
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
              0, 1:    gap_left = 0;
              5:       gap_left = $urandom_range(20, 40);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_seen >= next_hold_at) begin
      // long back-pressure so the block fills and stalls its input
      hold_left = LONG_HOLD - 1;
      next_hold_at += 120;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= 1'($urandom_range(0, 1));
        RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        default:   out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_values.size() == 0) begin
        log_failure($sformatf("unexpected result %h with nothing pending", out_poly_value));
      end else begin
        want_value = expected_values.pop_front();
        if (want_value !== out_poly_value) begin
          log_failure($sformatf("result %0d: poly_value expected %h got %h",
                                results_seen, want_value, out_poly_value));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [CFG_W-1:0] phase_deg [7];
    int p;
    phase_deg = '{4'd12, 4'd15, 4'd0, 4'd1, 4'd5, 4'd9, 4'd0};
    phase_deg[6] = CFG_W'($urandom_range(2, 11));
    foreach (coef_tbl[i]) coef_tbl[i] = '0;
    foreach (row_coef[i]) row_coef[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // evaluate straight out of reset, degree still zero
    push_cmd(OP_EVAL, 7'd0, '0, Q_ONE);
    drain(SETTLE_CYCLES);
    set_degree(4'd2);

    push_cmd(OP_EVAL, 7'd127, Q_MAX, Q_ONE);
    push_cmd(OP_NONE, 7'd0, Q_ONE, Q_ONE);
    push_cmd(OP_WRITE, 7'd0, Q_ONE, '0);
    push_cmd(OP_WRITE, 7'd1, 32'sh0002_0000, '0);
    push_cmd(OP_WRITE, 7'd2, 32'shFFFE_8000, '0);
    push_cmd(OP_WRITE, 7'd3, Q_MAX, '0);
    push_cmd(OP_WRITE, 7'd4, Q_MIN, '0);
    push_cmd(OP_WRITE, 7'd5, 32'sh0000_8000, '0);
    // writes past the end of the table are dropped
    push_cmd(OP_WRITE, 7'd127, 32'sh1234_5678, '0);
    push_cmd(OP_WRITE, 7'd91, Q_MIN, '0);
    push_cmd(OP_SET_Y, 7'd0, '0, '0);
    push_cmd(OP_EVAL, 7'd0, '0, '0);
    push_cmd(OP_EVAL, 7'd0, '0, Q_MAX);
    push_cmd(OP_EVAL, 7'd0, '0, Q_MIN);
    push_cmd(OP_SET_Y, 7'd0, '0, Q_MAX);
    push_cmd(OP_EVAL, 7'd0, '0, 32'shFFFF_0000);
    push_cmd(OP_SET_Y, 7'd0, '0, Q_MIN);
    push_cmd(OP_EVAL, 7'd0, '0, 32'sh0002_0000);
    push_cmd(OP_SET_Y, 7'd0, '0, 32'shFFFF_FFFF);
    push_cmd(OP_EVAL, 7'd0, '0, 32'shFFFF_FFFF);
    push_cmd(OP_NONE, 7'd127, Q_MIN, Q_MIN);
    push_cmd(OP_EVAL, 7'd0, '0, Q_ONE);

    for (p = 0; p < 7; p++) begin
      drain(SETTLE_CYCLES);
      set_degree(phase_deg[p]);
      build_phase(PHASE_ITEMS);
    end
    drain(SETTLE_CYCLES);

    if (expected_values.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", expected_values.size()));
    end
    $display("covered %0d items: %0d coefficient writes, %0d y collapses, %0d x evals, %0d ignored",
             n_accepted, n_writes, n_collapses, n_evals, n_ignored);
    $display("%0d degree settings, %0d results checked, %0d failures",
             n_degrees, results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d of %0d items taken, %0d results pending",
             n_accepted, n_queued, expected_values.size());
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
src/bpe_pkg.sv
src/bpe_ram.sv
src/bivariate_polynomial_evaluator.sv
src/bpe_checker.sv
bench/bivariate_polynomial_evaluator_test.sv
